// ===== hdl/per_uid_traffic_counter_table_assert.svh =====
// assertion macros for the per-key traffic counter table checker
// depends on nothing; expects a clock and reset signal in the using scope
`ifndef PER_UID_TRAFFIC_COUNTER_TABLE_ASSERT_SVH
`define PER_UID_TRAFFIC_COUNTER_TABLE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PCTT_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pctt assertion failed");

// next-cycle implication, disabled during reset
`define PCTT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pctt assertion failed");

`endif

// ===== hdl/pctt_pkg.sv =====
// shared types and constants of the per-key traffic counter table
// depends on nothing
package pctt_pkg;

   localparam logic [1:0]  ACT_TX   = 2'd0;
   localparam logic [1:0]  ACT_RX   = 2'd1;
   localparam logic [1:0]  ACT_READ = 2'd2;
   localparam logic [31:0] KEY_NONE = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [31:0] key;
      logic [63:0] tx;
      logic [63:0] rx;
   } entry_type;

   typedef struct packed {
      logic [63:0] addend_a;
      logic [63:0] addend_b;
      logic [31:0] key_a;
      logic [31:0] key_b;
   } alu_req_type;

   typedef struct packed {
      logic [63:0] sum;
      logic        key_eq;
   } alu_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CMP,
      ST_UPDATE,
      ST_INSERT,
      ST_RD_ISSUE,
      ST_RD_LOAD,
      ST_RD_WAIT,
      ST_TERM,
      ST_TERM_WAIT
   } state_type;

endpackage

// ===== hdl/pctt_alu.sv =====
// shared arithmetic unit: 64-bit wrapping adder and key comparator
// depends on pctt_pkg
module pctt_alu
   import pctt_pkg::*;
(
   input  alu_req_type alu_req,
   output alu_rsp_type alu_rsp
);

   // sum wraps modulo 2^64
   assign alu_rsp.sum    = alu_req.addend_a + alu_req.addend_b;
   assign alu_rsp.key_eq = (alu_req.key_a == alu_req.key_b);

endmodule

// ===== hdl/per_uid_traffic_counter_table.sv =====
// Per-key traffic counter table. Each entry holds a 32-bit key with a
// transmit and a receive 64-bit byte counter. An add word (action tx or rx)
// looks its key up by a linear scan of the stored entries, each entry read
// and then compared through the one shared comparator, then adds the byte
// count with the shared 64-bit adder (or creates the entry); adds with key
// -1 or zero bytes are dropped without touching the table. When all ENTRIES
// slots are taken a new key is discarded and a sticky overflow flag is set.
// A read word emits every entry newest first, in three steps each through
// the table's read port (read, load and clear, hand over), plus the wait on
// rsp_ready, then a terminator word with key -1, zero counts, last set and
// the overflow flag; the read zeroes all counters and the flag but keeps the
// keys. req_ready is high only while the block is idle. The table is a
// one-read one-write memory with a registered read port; no clearing pass is
// needed since only slots below the fill count are ever read.
// depends on pctt_pkg and pctt_alu
module per_uid_traffic_counter_table
   import pctt_pkg::*;
#(
   parameter int ENTRIES = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic        [1:0]  req_action,
   input  logic signed [31:0] req_app_uid,
   input  logic        [63:0] req_bytes,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_entry_uid,
   output logic        [63:0] rsp_tx_total,
   output logic        [63:0] rsp_rx_total,
   output logic               rsp_last,
   output logic               rsp_overflowed
);

   // slot index and fill count widths
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   // sequencer state
   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   used_ff, used_in;
   logic               dropped_ff, dropped_in;

   // captured request word
   logic [1:0]         action_ff, action_in;
   logic [31:0]        key_ff, key_in;
   logic [63:0]        bytes_ff, bytes_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_key_ff, rsp_key_in;
   logic [63:0]        rsp_tx_ff, rsp_tx_in;
   logic [63:0]        rsp_rx_ff, rsp_rx_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   // table memory, one write and one registered read port
   entry_type          table_mem [ENTRIES];
   entry_type          rd_data_ff;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_data;

   // shared adder and comparator
   alu_req_type        alu_req;
   alu_rsp_type        alu_rsp;

   logic               req_fire;
   logic               rsp_fire;
   logic               add_live;
   logic [CNT_W-1:0]   idx_next_cnt;
   logic               is_tx;

   pctt_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;
   assign is_tx     = (action_ff == ACT_TX);

   // an add that goes on to the table (not dropped while idle)
   assign add_live = ((req_action == ACT_TX) || (req_action == ACT_RX))
                     && (req_app_uid != KEY_NONE) && (req_bytes != 64'd0);

   assign idx_next_cnt = CNT_W'(idx_ff) + CNT_W'(1);

   // adder picks the counter named by the action, compare against held key
   always_comb begin
      alu_req.addend_a = is_tx ? rd_data_ff.tx : rd_data_ff.rx;
      alu_req.addend_b = bytes_ff;
      alu_req.key_a    = rd_data_ff.key;
      alu_req.key_b    = key_ff;
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      used_in      = used_ff;
      dropped_in   = dropped_ff;
      action_in    = action_ff;
      key_in       = key_ff;
      bytes_in     = bytes_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_tx_in    = rsp_tx_ff;
      rsp_rx_in    = rsp_rx_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rd_en        = 1'b0;
      rd_addr      = idx_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = rd_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               action_in = req_action;
               key_in    = req_app_uid;
               bytes_in  = req_bytes;
               idx_in    = '0;
               if (add_live) begin
                  // empty table goes straight to insert
                  state_in = (used_ff == '0) ? ST_INSERT : ST_SCAN;
               end else if (req_action == ACT_READ) begin
                  if (used_ff == '0) begin
                     state_in = ST_TERM;
                  end else begin
                     idx_in   = IDX_W'(used_ff - CNT_W'(1));
                     state_in = ST_RD_ISSUE;
                  end
               end
            end
         end
         ST_SCAN: begin
            rd_en    = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (alu_rsp.key_eq) begin
               state_in = ST_UPDATE;
            end else if (idx_next_cnt < used_ff) begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_SCAN;
            end else begin
               state_in = ST_INSERT;
            end
         end
         ST_UPDATE: begin
            // matched entry still sits in the read register
            wr_en      = 1'b1;
            wr_data.tx = is_tx ? alu_rsp.sum : rd_data_ff.tx;
            wr_data.rx = is_tx ? rd_data_ff.rx : alu_rsp.sum;
            state_in   = ST_IDLE;
         end
         ST_INSERT: begin
            if (used_ff != CNT_W'(ENTRIES)) begin
               wr_en       = 1'b1;
               wr_addr     = IDX_W'(used_ff);
               wr_data.key = key_ff;
               wr_data.tx  = is_tx ? bytes_ff : 64'd0;
               wr_data.rx  = is_tx ? 64'd0 : bytes_ff;
               used_in     = used_ff + CNT_W'(1);
            end else begin
               dropped_in = 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_RD_ISSUE: begin
            rd_en    = 1'b1;
            state_in = ST_RD_LOAD;
         end
         ST_RD_LOAD: begin
            // report the entry and zero its counters, key kept
            rsp_valid_in = 1'b1;
            rsp_key_in   = rd_data_ff.key;
            rsp_tx_in    = rd_data_ff.tx;
            rsp_rx_in    = rd_data_ff.rx;
            rsp_last_in  = 1'b0;
            rsp_ovf_in   = 1'b0;
            wr_en        = 1'b1;
            wr_data.tx   = 64'd0;
            wr_data.rx   = 64'd0;
            state_in     = ST_RD_WAIT;
         end
         ST_RD_WAIT: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               if (idx_ff == '0) begin
                  state_in = ST_TERM;
               end else begin
                  idx_in   = idx_ff - IDX_W'(1);
                  state_in = ST_RD_ISSUE;
               end
            end
         end
         ST_TERM: begin
            rsp_valid_in = 1'b1;
            rsp_key_in   = KEY_NONE;
            rsp_tx_in    = 64'd0;
            rsp_rx_in    = 64'd0;
            rsp_last_in  = 1'b1;
            rsp_ovf_in   = dropped_ff;
            dropped_in   = 1'b0;
            state_in     = ST_TERM_WAIT;
         end
         ST_TERM_WAIT: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      action_ff   <= action_in;
      key_ff      <= key_in;
      bytes_ff    <= bytes_in;
      rsp_key_ff  <= rsp_key_in;
      rsp_tx_ff   <= rsp_tx_in;
      rsp_rx_ff   <= rsp_rx_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   // table write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
   end

   // table read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_entry_uid  = $signed(rsp_key_ff);
   assign rsp_tx_total   = rsp_tx_ff;
   assign rsp_rx_total   = rsp_rx_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_overflowed = rsp_ovf_ff;

endmodule

// ===== hdl/pctt_checker.sv =====
// port-level checker for the per-key traffic counter table, with its bind
// depends on pctt_pkg and per_uid_traffic_counter_table_assert.svh
`include "per_uid_traffic_counter_table_assert.svh"

module pctt_checker
   import pctt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic        [1:0]  req_action,
   input  logic signed [31:0] req_app_uid,
   input  logic        [63:0] req_bytes,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_entry_uid,
   input  logic        [63:0] rsp_tx_total,
   input  logic        [63:0] rsp_rx_total,
   input  logic               rsp_last,
   input  logic               rsp_overflowed
);

   // a read always makes the block busy
   `PCTT_ASSERT_NEXT(a_read_busy, req_valid && req_ready && (req_action == ACT_READ), !req_ready)

   // no new word taken while a dump word is pending
   `PCTT_ASSERT_IMPLY(a_busy_rsp, rsp_valid, !req_ready)

   // overflow only reported on the terminator
   `PCTT_ASSERT_IMPLY(a_ovf_term, rsp_valid && !rsp_last, !rsp_overflowed)

   // terminator shape
   `PCTT_ASSERT_IMPLY(a_term_shape, rsp_valid && rsp_last, (rsp_entry_uid == -32'sd1) && (rsp_tx_total == 64'd0) && (rsp_rx_total == 64'd0))

   // stalled result word holds
   `PCTT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_entry_uid) && $stable(rsp_tx_total) && $stable(rsp_rx_total))

endmodule

bind per_uid_traffic_counter_table pctt_checker u_pctt_checker (.*);
